### design/entropy_to_mnemonic_indices_defines.svh
// assertion helpers for the top design file
`ifndef ENTROPY_TO_MNEMONIC_INDICES_DEFINES_SVH
`define ENTROPY_TO_MNEMONIC_INDICES_DEFINES_SVH

// same-cycle implication
`define ETMI_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ETMI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/etmi_pkg.sv
`default_nettype none
package etmi_pkg;
	localparam int INDEX_BITS = 11;

	typedef struct packed {
		logic        go;
		logic        wr_en;
		logic [3:0]  wr_addr;
		logic [31:0] wr_data;
	} sha_ctl_t;

	typedef struct packed {
		logic       done;
		logic [7:0] check_byte;
	} sha_sts_t;
endpackage
`default_nettype wire

### design/etmi_sha.sv
`default_nettype none
module etmi_sha (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire etmi_pkg::sha_ctl_t ctl,
	output etmi_pkg::sha_sts_t     sts
);
	localparam logic [2:0] P_IDLE = 3'd0;
	localparam logic [2:0] P_RD0  = 3'd1;
	localparam logic [2:0] P_RD1  = 3'd2;
	localparam logic [2:0] P_RND  = 3'd3;
	localparam logic [2:0] P_FIN  = 3'd4;

	localparam logic [255:0] IV = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] round_k(input logic [5:0] t);
		case (t)
			6'd0: round_k = 32'h428a2f98; 6'd1: round_k = 32'h71374491;
			6'd2: round_k = 32'hb5c0fbcf; 6'd3: round_k = 32'he9b5dba5;
			6'd4: round_k = 32'h3956c25b; 6'd5: round_k = 32'h59f111f1;
			6'd6: round_k = 32'h923f82a4; 6'd7: round_k = 32'hab1c5ed5;
			6'd8: round_k = 32'hd807aa98; 6'd9: round_k = 32'h12835b01;
			6'd10: round_k = 32'h243185be; 6'd11: round_k = 32'h550c7dc3;
			6'd12: round_k = 32'h72be5d74; 6'd13: round_k = 32'h80deb1fe;
			6'd14: round_k = 32'h9bdc06a7; 6'd15: round_k = 32'hc19bf174;
			6'd16: round_k = 32'he49b69c1; 6'd17: round_k = 32'hefbe4786;
			6'd18: round_k = 32'h0fc19dc6; 6'd19: round_k = 32'h240ca1cc;
			6'd20: round_k = 32'h2de92c6f; 6'd21: round_k = 32'h4a7484aa;
			6'd22: round_k = 32'h5cb0a9dc; 6'd23: round_k = 32'h76f988da;
			6'd24: round_k = 32'h983e5152; 6'd25: round_k = 32'ha831c66d;
			6'd26: round_k = 32'hb00327c8; 6'd27: round_k = 32'hbf597fc7;
			6'd28: round_k = 32'hc6e00bf3; 6'd29: round_k = 32'hd5a79147;
			6'd30: round_k = 32'h06ca6351; 6'd31: round_k = 32'h14292967;
			6'd32: round_k = 32'h27b70a85; 6'd33: round_k = 32'h2e1b2138;
			6'd34: round_k = 32'h4d2c6dfc; 6'd35: round_k = 32'h53380d13;
			6'd36: round_k = 32'h650a7354; 6'd37: round_k = 32'h766a0abb;
			6'd38: round_k = 32'h81c2c92e; 6'd39: round_k = 32'h92722c85;
			6'd40: round_k = 32'ha2bfe8a1; 6'd41: round_k = 32'ha81a664b;
			6'd42: round_k = 32'hc24b8b70; 6'd43: round_k = 32'hc76c51a3;
			6'd44: round_k = 32'hd192e819; 6'd45: round_k = 32'hd6990624;
			6'd46: round_k = 32'hf40e3585; 6'd47: round_k = 32'h106aa070;
			6'd48: round_k = 32'h19a4c116; 6'd49: round_k = 32'h1e376c08;
			6'd50: round_k = 32'h2748774c; 6'd51: round_k = 32'h34b0bcb5;
			6'd52: round_k = 32'h391c0cb3; 6'd53: round_k = 32'h4ed8aa4a;
			6'd54: round_k = 32'h5b9cca4f; 6'd55: round_k = 32'h682e6ff3;
			6'd56: round_k = 32'h748f82ee; 6'd57: round_k = 32'h78a5636f;
			6'd58: round_k = 32'h84c87814; 6'd59: round_k = 32'h8cc70208;
			6'd60: round_k = 32'h90befffa; 6'd61: round_k = 32'ha4506ceb;
			6'd62: round_k = 32'hbef9a3f7; 6'd63: round_k = 32'hc67178f2;
			default: round_k = 32'h0;
		endcase
	endfunction

	logic [31:0] sched_mem [16];
	logic [31:0] rd0_q, rd1_q;
	logic [3:0]  ra0, ra1, wa;
	logic        we;
	logic [31:0] wd;

	logic [2:0]  ph_q;
	logic [5:0]  t_q;
	logic [31:0] va_q, vb_q, vc_q, vd_q, ve_q, vf_q, vg_q, vh_q;
	logic [31:0] ss_q, hk_q;
	logic        done_q;
	logic [7:0]  chk_q;

	logic [31:0] s0, s1, w, bs0, bs1, ch, maj, t1, t2;

	always_comb begin
		ra0 = 4'(t_q + 6'd1);
		ra1 = 4'(t_q + 6'd14);
		if (ph_q == P_RD1) begin
			ra0 = 4'(t_q + 6'd9);
			ra1 = t_q[3:0];
		end
	end

	always_comb begin
		s0  = rotr(rd0_q, 7) ^ rotr(rd0_q, 18) ^ (rd0_q >> 3);
		s1  = rotr(rd1_q, 17) ^ rotr(rd1_q, 19) ^ (rd1_q >> 10);
		w   = (t_q < 6'd16) ? rd1_q : rd1_q + rd0_q + ss_q;
		bs1 = rotr(ve_q, 6) ^ rotr(ve_q, 11) ^ rotr(ve_q, 25);
		ch  = (ve_q & vf_q) ^ (~ve_q & vg_q);
		bs0 = rotr(va_q, 2) ^ rotr(va_q, 13) ^ rotr(va_q, 22);
		maj = (va_q & vb_q) ^ (va_q & vc_q) ^ (vb_q & vc_q);
		t1  = hk_q + bs1 + ch + w;
		t2  = bs0 + maj;
	end

	always_comb begin
		we = ctl.wr_en;
		wa = ctl.wr_addr;
		wd = ctl.wr_data;
		if (ph_q == P_RND) begin
			we = 1'b1;
			wa = t_q[3:0];
			wd = w;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			sched_mem[wa] <= wd;
		end
		rd0_q <= sched_mem[ra0];
		rd1_q <= sched_mem[ra1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= P_IDLE;
			t_q    <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (ph_q)
				P_IDLE: begin
					if (ctl.go) begin
						ph_q <= P_RD0;
						t_q  <= '0;
					end
				end
				P_RD0: ph_q <= P_RD1;
				P_RD1: ph_q <= P_RND;
				P_RND: begin
					t_q  <= t_q + 6'd1;
					ph_q <= (t_q == 6'd63) ? P_FIN : P_RD0;
				end
				P_FIN: begin
					done_q <= 1'b1;
					ph_q   <= P_IDLE;
				end
				default: ph_q <= P_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ph_q)
			P_IDLE: begin
				if (ctl.go) begin
					{va_q, vb_q, vc_q, vd_q, ve_q, vf_q, vg_q, vh_q} <= IV;
				end
			end
			P_RD1: begin
				ss_q <= s0 + s1;
				hk_q <= vh_q + round_k(t_q);
			end
			P_RND: begin
				vh_q <= vg_q;
				vg_q <= vf_q;
				vf_q <= ve_q;
				ve_q <= vd_q + t1;
				vd_q <= vc_q;
				vc_q <= vb_q;
				vb_q <= va_q;
				va_q <= t1 + t2;
			end
			P_FIN: chk_q <= 8'((IV[255:224] + va_q) >> 24);
			default: ;
		endcase
	end

	assign sts.done       = done_q;
	assign sts.check_byte = chk_q;
endmodule
`default_nettype wire

### design/entropy_to_mnemonic_indices.sv
`default_nettype none
// entropy to mnemonic word indices
// input: one entropy word (byte) per accepted command, start high while busy
// is low; final_byte marks the last byte of a run.
// output: results appear one cycle each with word_valid high; they cannot be
// held off by the receiver and are never retried.
// a run of bad length (not 16..MAX bytes in steps of 4, or overrun) gives one
// error word the cycle after its last byte, and the block stays ready.
// a valid run of L bytes: busy rises after the last byte; the padded block is
// copied into the schedule memory, the hash steps each of its 64 rounds through
// its RD0, RD1 and RND phases (two-read-port schedule memory) and ends in a FIN
// phase, then the L*3/4 indices come out at most one per byte read.
// reset clears the byte count and the state machines; memory contents are not cleared.
module entropy_to_mnemonic_indices #(
	parameter int MAX_ENTROPY_BYTES = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [7:0]  entropy_byte,
	input  wire logic        final_byte,
	output logic             word_valid,
	output logic [10:0]      word_index,
	output logic             last_word,
	output logic             length_error
);
	`include "entropy_to_mnemonic_indices_defines.svh"

	localparam int AW = $clog2(MAX_ENTROPY_BYTES);
	localparam int CW = $clog2(MAX_ENTROPY_BYTES + 1);
	localparam int IB = etmi_pkg::INDEX_BITS;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_LOAD = 2'd1;
	localparam logic [1:0] S_HASH = 2'd2;
	localparam logic [1:0] S_EMIT = 2'd3;

	logic [7:0]  ent_mem [MAX_ENTROPY_BYTES];
	logic [7:0]  ent_rd_q;
	logic [AW-1:0] raddr;

	logic [1:0]  st_q;
	logic [CW-1:0] cnt_q, len_q, cnt_nx;
	logic        ovf_q, ovf_nx, len_ok;
	logic [5:0]  k_q, k_s1;
	logic        vld_s1;
	logic [23:0] wacc_q;
	logic [7:0]  blk_byte;
	logic [15:0] len_bits;
	logic [4:0]  words_q, emit_q;
	logic [4:0]  nb_q;
	logic [17:0] buf_q, nbuf;
	logic [4:0]  nnb;
	logic [7:0]  emit_byte;
	logic        go_q, acc;

	etmi_pkg::sha_ctl_t ctl;
	etmi_pkg::sha_sts_t sts;

	assign acc = start && !busy;
	assign busy = (st_q != S_IDLE);
	assign cnt_nx = (cnt_q < CW'(MAX_ENTROPY_BYTES)) ? cnt_q + 1'b1 : cnt_q;
	assign ovf_nx = ovf_q || (cnt_q == CW'(MAX_ENTROPY_BYTES));
	assign len_ok = !ovf_nx && (cnt_nx >= CW'(16)) && (cnt_nx[1:0] == 2'b00);
	assign len_bits = 16'({len_q, 3'b000});
	assign raddr = k_q[AW-1:0];

	always_comb begin
		if ({1'b0, k_s1} < 7'(len_q)) begin
			blk_byte = ent_rd_q;
		end else if ({1'b0, k_s1} == 7'(len_q)) begin
			blk_byte = 8'h80;
		end else if (k_s1 == 6'd62) begin
			blk_byte = len_bits[15:8];
		end else if (k_s1 == 6'd63) begin
			blk_byte = len_bits[7:0];
		end else begin
			blk_byte = 8'h00;
		end
	end

	always_comb begin
		emit_byte = ({1'b0, k_s1} == 7'(len_q)) ? sts.check_byte : ent_rd_q;
		nbuf = {buf_q[9:0], emit_byte};
		nnb  = nb_q + 5'd8;
	end

	always_comb begin
		ctl.go      = go_q;
		ctl.wr_en   = (st_q == S_LOAD) && vld_s1 && (k_s1[1:0] == 2'b11);
		ctl.wr_addr = k_s1[5:2];
		ctl.wr_data = {wacc_q, blk_byte};
	end

	etmi_sha u_sha (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.sts    (sts)
	);

	always_ff @(posedge clk) begin
		if (acc && (cnt_q < CW'(MAX_ENTROPY_BYTES))) begin
			ent_mem[cnt_q[AW-1:0]] <= entropy_byte;
		end
		ent_rd_q <= ent_mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= S_IDLE;
			cnt_q      <= '0;
			ovf_q      <= 1'b0;
			vld_s1     <= 1'b0;
			go_q       <= 1'b0;
			word_valid <= 1'b0;
			k_q        <= '0;
			emit_q     <= '0;
			nb_q       <= '0;
		end else begin
			word_valid <= 1'b0;
			go_q       <= 1'b0;
			case (st_q)
				S_IDLE: begin
					vld_s1 <= 1'b0;
					if (acc) begin
						cnt_q <= cnt_nx;
						ovf_q <= ovf_nx;
						if (final_byte) begin
							cnt_q <= '0;
							ovf_q <= 1'b0;
							if (len_ok) begin
								st_q <= S_LOAD;
								k_q  <= '0;
							end else begin
								word_valid <= 1'b1;
							end
						end
					end
				end
				S_LOAD: begin
					vld_s1 <= (k_q != 6'd63) || !vld_s1;
					if (k_q != 6'd63) begin
						k_q <= k_q + 6'd1;
					end
					if (vld_s1 && (k_s1 == 6'd63)) begin
						vld_s1 <= 1'b0;
						go_q   <= 1'b1;
						st_q   <= S_HASH;
					end
				end
				S_HASH: begin
					if (sts.done) begin
						st_q   <= S_EMIT;
						k_q    <= '0;
						emit_q <= '0;
						nb_q   <= '0;
						vld_s1 <= 1'b0;
					end
				end
				S_EMIT: begin
					vld_s1 <= ({1'b0, k_q} <= 7'(len_q));
					if ({1'b0, k_q} <= 7'(len_q)) begin
						k_q <= k_q + 6'd1;
					end
					if (vld_s1) begin
						if (nnb >= 5'(IB)) begin
							nb_q       <= nnb - 5'(IB);
							word_valid <= 1'b1;
							emit_q     <= emit_q + 5'd1;
							if (emit_q == words_q - 5'd1) begin
								st_q <= S_IDLE;
							end
						end else begin
							nb_q <= nnb;
						end
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		k_s1 <= k_q;
		if (st_q == S_IDLE && acc && final_byte) begin
			len_q   <= cnt_nx;
			words_q <= 5'({cnt_nx[CW-1:2], 1'b0}) + 5'(cnt_nx[CW-1:2]);
			word_index   <= '0;
			last_word    <= 1'b1;
			length_error <= 1'b1;
		end
		if (st_q == S_LOAD && vld_s1) begin
			wacc_q <= {wacc_q[15:0], blk_byte};
		end
		if (st_q == S_EMIT && vld_s1) begin
			buf_q        <= nbuf;
			word_index   <= 11'(nbuf >> (nnb - 5'(IB)));
			last_word    <= (emit_q == words_q - 5'd1);
			length_error <= 1'b0;
		end
	end

	`ETMI_ASSERT_NOW(a_err_word, word_valid && length_error, (word_index == 11'd0) && last_word, "error word malformed")
	`ETMI_ASSERT_NOW(a_emit_bound, st_q == S_EMIT, emit_q < words_q, "emitted too many words")
	`ETMI_ASSERT_NOW(a_done_in_hash, sts.done, st_q == S_HASH, "hash done outside hash phase")
	`ETMI_ASSERT_NEXT(a_go_pulse, go_q, !go_q && (st_q == S_HASH), "hash start not a single pulse")
endmodule
`default_nettype wire
